/* rtl/core/vfsg_pkg.sv */
// Shared types, constants and the constant stroke ROM of the vector font stroke generator.
// No dependencies; every other file of the block but vfsg_sat_add imports this package.
package vfsg_pkg;

    localparam int unsigned COORD_OUT_BITS = 12;
    localparam int unsigned CODE_BITS      = 7;
    localparam int unsigned ROM_SLOTS      = 8;
    localparam int unsigned ENTRY_BITS     = 11;
    localparam logic [CODE_BITS-1:0] FIRST_CODE = 7'h20;

    // Slot entry: bit 10 marks a point, bit 8 a pen-up, [7:4] glyph x, [3:0] glyph y.
    localparam int unsigned PT_BIT = 10;
    localparam int unsigned UP_BIT = 8;

    typedef logic [ENTRY_BITS-1:0] t_entry;
    typedef t_entry [0:ROM_SLOTS-1] t_glyph;

    localparam t_entry ENDM = 11'h000;
    localparam t_entry UPM  = 11'h100;

    typedef struct packed {
        logic [COORD_OUT_BITS-1:0] from_x;
        logic [COORD_OUT_BITS-1:0] from_y;
        logic [COORD_OUT_BITS-1:0] to_x;
        logic [COORD_OUT_BITS-1:0] to_y;
        logic                      last_segment;
    } t_seg;

    function automatic t_entry pt(input int x, input int y);
        return {1'b1, 2'b00, 4'(x), 4'(y)};
    endfunction

    // Glyph table indexed by character code minus 0x20; unlisted rows hold end marks only.
    function automatic t_glyph glyph_rom(input logic [CODE_BITS-1:0] row);
        t_glyph g;
        case (row)
            7'd1:  g = '{pt(4,0), pt(3,2), pt(5,2), pt(4,0), UPM, pt(4,4), pt(4,12), ENDM};
            7'd2:  g = '{pt(2,10), pt(2,6), UPM, pt(6,10), pt(6,6), ENDM, ENDM, ENDM};
            7'd3:  g = '{pt(0,4), pt(8,4), pt(6,2), pt(6,10), pt(8,8), pt(0,8), pt(2,10),
                         pt(2,2)};
            7'd4:  g = '{pt(6,2), pt(2,6), pt(6,10), UPM, pt(4,12), pt(4,0), ENDM, ENDM};
            7'd5:  g = '{pt(0,0), pt(8,12), UPM, pt(2,10), pt(2,8), UPM, pt(6,4), pt(6,2)};
            7'd6:  g = '{pt(8,0), pt(4,12), pt(8,8), pt(0,4), pt(4,0), pt(8,4), ENDM, ENDM};
            7'd7:  g = '{pt(2,6), pt(6,10), ENDM, ENDM, ENDM, ENDM, ENDM, ENDM};
            7'd8:  g = '{pt(6,0), pt(2,4), pt(2,8), pt(6,12), ENDM, ENDM, ENDM, ENDM};
            7'd9:  g = '{pt(2,0), pt(6,4), pt(6,8), pt(2,12), ENDM, ENDM, ENDM, ENDM};
            7'd10: g = '{pt(0,0), pt(4,12), pt(8,0), pt(0,8), pt(8,8), pt(0,0), ENDM, ENDM};
            7'd11: g = '{pt(1,6), pt(7,6), UPM, pt(4,9), pt(4,3), ENDM, ENDM, ENDM};
            7'd12: g = '{pt(2,0), pt(4,2), ENDM, ENDM, ENDM, ENDM, ENDM, ENDM};
            7'd13: g = '{pt(2,6), pt(6,6), ENDM, ENDM, ENDM, ENDM, ENDM, ENDM};
            7'd14: g = '{pt(3,0), pt(4,0), ENDM, ENDM, ENDM, ENDM, ENDM, ENDM};
            7'd15: g = '{pt(0,0), pt(8,12), ENDM, ENDM, ENDM, ENDM, ENDM, ENDM};
            7'd16: g = '{pt(0,0), pt(8,0), pt(8,12), pt(0,12), pt(0,0), pt(8,12), ENDM, ENDM};
            7'd17: g = '{pt(4,0), pt(4,12), pt(3,10), ENDM, ENDM, ENDM, ENDM, ENDM};
            7'd18: g = '{pt(0,12), pt(8,12), pt(8,7), pt(0,5), pt(0,0), pt(8,0), ENDM, ENDM};
            7'd19: g = '{pt(0,12), pt(8,12), pt(8,0), pt(0,0), UPM, pt(0,6), pt(8,6), ENDM};
            7'd20: g = '{pt(0,12), pt(0,6), pt(8,6), UPM, pt(8,12), pt(8,0), ENDM, ENDM};
            7'd21: g = '{pt(0,0), pt(8,0), pt(8,6), pt(0,7), pt(0,12), pt(8,12), ENDM, ENDM};
            7'd22: g = '{pt(0,12), pt(0,0), pt(8,0), pt(8,5), pt(0,7), ENDM, ENDM, ENDM};
            7'd23: g = '{pt(0,12), pt(8,12), pt(8,6), pt(4,0), ENDM, ENDM, ENDM, ENDM};
            7'd24: g = '{pt(0,0), pt(8,0), pt(8,12), pt(0,12), pt(0,0), UPM, pt(0,6), pt(8,6)};
            7'd25: g = '{pt(8,0), pt(8,12), pt(0,12), pt(0,7), pt(8,5), ENDM, ENDM, ENDM};
            7'd26: g = '{pt(4,9), pt(4,7), UPM, pt(4,5), pt(4,3), ENDM, ENDM, ENDM};
            7'd27: g = '{pt(4,9), pt(4,7), UPM, pt(4,5), pt(1,2), ENDM, ENDM, ENDM};
            7'd28: g = '{pt(6,0), pt(2,6), pt(6,12), ENDM, ENDM, ENDM, ENDM, ENDM};
            7'd29: g = '{pt(1,4), pt(7,4), UPM, pt(1,8), pt(7,8), ENDM, ENDM, ENDM};
            7'd30: g = '{pt(2,0), pt(6,6), pt(2,12), ENDM, ENDM, ENDM, ENDM, ENDM};
            7'd31: g = '{pt(0,8), pt(4,12), pt(8,8), pt(4,4), UPM, pt(4,1), pt(4,0), ENDM};
            7'd32: g = '{pt(8,4), pt(4,0), pt(0,4), pt(0,8), pt(4,12), pt(8,8), pt(4,4),
                         pt(3,6)};
            7'd33: g = '{pt(0,0), pt(0,8), pt(4,12), pt(8,8), pt(8,0), UPM, pt(0,4), pt(8,4)};
            7'd34: g = '{pt(0,0), pt(0,12), pt(4,12), pt(8,10), pt(4,6), pt(8,2), pt(4,0),
                         pt(0,0)};
            7'd35: g = '{pt(8,0), pt(0,0), pt(0,12), pt(8,12), ENDM, ENDM, ENDM, ENDM};
            7'd36: g = '{pt(0,0), pt(0,12), pt(4,12), pt(8,8), pt(8,4), pt(4,0), pt(0,0),
                         ENDM};
            7'd37: g = '{pt(8,0), pt(0,0), pt(0,12), pt(8,12), UPM, pt(0,6), pt(6,6), ENDM};
            7'd38: g = '{pt(0,0), pt(0,12), pt(8,12), UPM, pt(0,6), pt(6,6), ENDM, ENDM};
            7'd39: g = '{pt(6,6), pt(8,4), pt(8,0), pt(0,0), pt(0,12), pt(8,12), ENDM, ENDM};
            7'd40: g = '{pt(0,0), pt(0,12), UPM, pt(0,6), pt(8,6), UPM, pt(8,12), pt(8,0)};
            7'd41: g = '{pt(0,0), pt(8,0), UPM, pt(4,0), pt(4,12), UPM, pt(0,12), pt(8,12)};
            7'd42: g = '{pt(0,4), pt(4,0), pt(8,0), pt(8,12), ENDM, ENDM, ENDM, ENDM};
            7'd43: g = '{pt(0,0), pt(0,12), UPM, pt(8,12), pt(0,6), pt(6,0), ENDM, ENDM};
            7'd44: g = '{pt(8,0), pt(0,0), pt(0,12), ENDM, ENDM, ENDM, ENDM, ENDM};
            7'd45: g = '{pt(0,0), pt(0,12), pt(4,8), pt(8,12), pt(8,0), ENDM, ENDM, ENDM};
            7'd46: g = '{pt(0,0), pt(0,12), pt(8,0), pt(8,12), ENDM, ENDM, ENDM, ENDM};
            7'd47: g = '{pt(0,0), pt(0,12), pt(8,12), pt(8,0), pt(0,0), ENDM, ENDM, ENDM};
            7'd48: g = '{pt(0,0), pt(0,12), pt(8,12), pt(8,6), pt(0,5), ENDM, ENDM, ENDM};
            7'd49: g = '{pt(0,0), pt(0,12), pt(8,12), pt(8,4), pt(0,0), UPM, pt(4,4), pt(8,0)};
            7'd50: g = '{pt(0,0), pt(0,12), pt(8,12), pt(8,6), pt(0,5), UPM, pt(4,5), pt(8,0)};
            7'd51: g = '{pt(0,2), pt(2,0), pt(8,0), pt(8,5), pt(0,7), pt(0,12), pt(6,12),
                         pt(8,10)};
            7'd52: g = '{pt(0,12), pt(8,12), UPM, pt(4,12), pt(4,0), ENDM, ENDM, ENDM};
            7'd53: g = '{pt(0,12), pt(0,2), pt(4,0), pt(8,2), pt(8,12), ENDM, ENDM, ENDM};
            7'd54: g = '{pt(0,12), pt(4,0), pt(8,12), ENDM, ENDM, ENDM, ENDM, ENDM};
            7'd55: g = '{pt(0,12), pt(2,0), pt(4,4), pt(6,0), pt(8,12), ENDM, ENDM, ENDM};
            7'd56: g = '{pt(0,0), pt(8,12), UPM, pt(0,12), pt(8,0), ENDM, ENDM, ENDM};
            7'd57: g = '{pt(0,12), pt(4,6), pt(8,12), UPM, pt(4,6), pt(4,0), ENDM, ENDM};
            7'd58: g = '{pt(0,12), pt(8,12), pt(0,0), pt(8,0), UPM, pt(2,6), pt(6,6), ENDM};
            7'd59: g = '{pt(6,0), pt(2,0), pt(2,12), pt(6,12), ENDM, ENDM, ENDM, ENDM};
            7'd60: g = '{pt(0,12), pt(8,0), ENDM, ENDM, ENDM, ENDM, ENDM, ENDM};
            7'd61: g = '{pt(2,0), pt(6,0), pt(6,12), pt(2,12), ENDM, ENDM, ENDM, ENDM};
            7'd62: g = '{pt(2,6), pt(4,12), pt(6,6), ENDM, ENDM, ENDM, ENDM, ENDM};
            7'd63: g = '{pt(0,0), pt(8,0), ENDM, ENDM, ENDM, ENDM, ENDM, ENDM};
            7'd64: g = '{pt(2,10), pt(6,6), ENDM, ENDM, ENDM, ENDM, ENDM, ENDM};
            7'd65: g = '{pt(0,0), pt(0,12), pt(7,12), pt(7,0), pt(0,0), ENDM, ENDM, ENDM};
            7'd66: g = '{pt(0,0), pt(4,12), pt(8,0), pt(0,0), ENDM, ENDM, ENDM, ENDM};
            7'd67: g = '{pt(0,6), pt(8,6), pt(8,7), pt(0,7), ENDM, ENDM, ENDM, ENDM};
            7'd91: g = '{pt(6,0), pt(4,2), pt(4,10), pt(6,12), UPM, pt(2,6), pt(4,6), ENDM};
            7'd92: g = '{pt(4,0), pt(4,5), UPM, pt(4,6), pt(4,12), ENDM, ENDM, ENDM};
            7'd93: g = '{pt(4,0), pt(6,2), pt(6,10), pt(4,12), UPM, pt(6,6), pt(8,6), ENDM};
            7'd94: g = '{pt(0,4), pt(2,8), pt(6,4), pt(8,8), ENDM, ENDM, ENDM, ENDM};
            default: g = '{ENDM, ENDM, ENDM, ENDM, ENDM, ENDM, ENDM, ENDM};
        endcase
        return g;
    endfunction

endpackage

/* rtl/core/vfsg_if.sv */
// Valid/ready channel interfaces of the vector font stroke generator.
// Depends on vfsg_pkg for the field widths.
interface vfsg_char_if import vfsg_pkg::*; ();
    logic                             valid;
    logic                             ready;
    logic [CODE_BITS-1:0]             char_code;
    logic                             new_string;
    logic signed [COORD_OUT_BITS-1:0] origin_x;
    logic signed [COORD_OUT_BITS-1:0] origin_y;

    modport source (output valid, char_code, new_string, origin_x, origin_y, input ready);
    modport sink   (input valid, char_code, new_string, origin_x, origin_y, output ready);
endinterface

interface vfsg_seg_if import vfsg_pkg::*; ();
    logic                             valid;
    logic                             ready;
    logic signed [COORD_OUT_BITS-1:0] from_x;
    logic signed [COORD_OUT_BITS-1:0] from_y;
    logic signed [COORD_OUT_BITS-1:0] to_x;
    logic signed [COORD_OUT_BITS-1:0] to_y;
    logic                             last_segment;

    modport source (output valid, from_x, from_y, to_x, to_y, last_segment, input ready);
    modport sink   (input valid, from_x, from_y, to_x, to_y, last_segment, output ready);
endinterface

/* rtl/core/vfsg_sat_add.sv */
// Shared saturating adder: a wide signed operand plus a small signed offset,
// clamped to the signed coordinate range. No package dependency.
module vfsg_sat_add #(
    parameter int AW = 12,
    parameter int CB = 12
) (
    input  logic signed [AW-1:0] i_a,
    input  logic signed [7:0]    i_b,
    output logic signed [CB-1:0] o_sum
);
    localparam int SW = AW + 2;
    localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (CB - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] LO = -HI - SW'(1);

    logic signed [SW-1:0] sum;

    assign sum = SW'(i_a) + SW'(i_b);

    always_comb begin
        if (sum > HI) begin
            o_sum = HI[CB-1:0];
        end else if (sum < LO) begin
            o_sum = LO[CB-1:0];
        end else begin
            o_sum = sum[CB-1:0];
        end
    end
endmodule

/* rtl/core/vfsg_out_reg.sv */
// Output register of the segment channel: holds one segment until the sink takes it.
// Depends on vfsg_pkg for t_seg.
module vfsg_out_reg import vfsg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_seg i_seg,
    output logic o_can_push,
    output logic o_valid,
    input  logic i_ready,
    output t_seg o_seg
);
    logic r_valid;
    logic n_valid;
    t_seg r_seg;

    assign o_can_push = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_seg      = r_seg;

    always_comb begin
        n_valid = r_valid;
        if (i_ready) begin
            n_valid = 1'b0;
        end
        if (i_push) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_seg <= i_seg;
        end
    end
endmodule

/* rtl/core/vector_font_stroke_generator.sv */
// Vector font stroke generator: turns character codes into glyph line segments.
// Depends on vfsg_pkg, vfsg_if, vfsg_sat_add and vfsg_out_reg.
//
// One character transaction is accepted on i_char when the block is idle; the block then
// walks the glyph's ROM slots one at a time under a small sequencer, with a single shared
// saturating adder doing every coordinate calculation. A point slot passes x then y through
// the adder (S_PX, then S_PY), a pen-up slot only S_PX, and the walk ends in S_FLUSH at the
// first end mark or after min(GLYPH_SLOTS, 8) slots; S_ADV then advances the origin before
// the block is idle again. A control code skips the walk and goes straight to S_ADV. A
// new_string reload passes through S_RLX and S_RLY first, and a stalled segment sink holds
// the walk in S_PY or S_FLUSH.
// Each segment is held one point back so that the final one of a character can carry
// last_segment; segments leave through an output register, so the sink may stall freely.
// Coordinates saturate to the signed COORD_BITS range and are presented as 12-bit values.
module vector_font_stroke_generator import vfsg_pkg::*; #(
    parameter int GLYPH_SLOTS  = 8,
    parameter int GLYPH_WIDTH  = 8,
    parameter int GLYPH_HEIGHT = 8,
    parameter int GLYPH_GAP    = 2,
    parameter int COORD_BITS   = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vfsg_char_if.sink     i_char,
    vfsg_seg_if.source    o_seg
);
    localparam int CB = COORD_BITS;
    // Operand width of the shared adder: wide enough for 12-bit origins and the state.
    localparam int AW = (CB > 12) ? CB : 12;
    localparam logic [3:0] SLOT_LIMIT = 4'((GLYPH_SLOTS < 8) ? GLYPH_SLOTS : 8);
    localparam logic signed [7:0] ADVANCE = 8'(GLYPH_WIDTH + GLYPH_GAP);
    localparam logic signed [7:0] HEIGHT  = 8'(GLYPH_HEIGHT);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RLX   = 3'd1;  // reload origin x
    localparam logic [2:0] S_RLY   = 3'd2;  // reload baseline
    localparam logic [2:0] S_PX    = 3'd3;  // fetch slot, screen x
    localparam logic [2:0] S_PY    = 3'd4;  // screen y, form segment
    localparam logic [2:0] S_FLUSH = 3'd5;  // release the held segment as last
    localparam logic [2:0] S_ADV   = 3'd6;  // advance origin

    logic [2:0] r_state, n_state;

    // Latched transaction
    logic [CODE_BITS-1:0]             r_code;
    logic signed [COORD_OUT_BITS-1:0] r_ox, r_oy;

    // Pen state
    logic signed [CB-1:0] r_cox, n_cox;
    logic signed [CB-1:0] r_base, n_base;
    logic signed [CB-1:0] r_px, n_px, r_py, n_py;
    logic signed [CB-1:0] r_nx, n_nx;
    logic                 r_pen, n_pen;
    logic [3:0]           r_slot, n_slot;

    // Held segment, one point behind the walk
    logic                 r_hold_v, n_hold_v;
    logic signed [CB-1:0] r_hfx, r_hfy, r_htx, r_hty;
    logic signed [CB-1:0] n_hfx, n_hfy, n_htx, n_hty;

    // Shared adder
    logic signed [AW-1:0] add_a;
    logic signed [7:0]    add_b;
    logic signed [CB-1:0] add_sum;

    // Output register hookup
    logic push, can_push, push_last;
    t_seg push_seg, out_seg;

    // Slot fetch
    logic [CODE_BITS-1:0] row;
    t_glyph               glyph;
    t_entry               entry;

    assign row   = r_code - FIRST_CODE;
    assign glyph = glyph_rom(row);
    assign entry = glyph[r_slot[2:0]];

    vfsg_sat_add #(.AW(AW), .CB(CB)) u_add (
        .i_a   (add_a),
        .i_b   (add_b),
        .o_sum (add_sum)
    );

    // Operand selection for the shared adder
    always_comb begin
        add_a = AW'(r_cox);
        add_b = '0;
        case (r_state)
            S_RLX: begin
                add_a = AW'(r_ox);
            end
            S_RLY: begin
                add_a = AW'(r_oy);
                add_b = HEIGHT;
            end
            S_PX: begin
                add_b = 8'({4'b0000, entry[7:4]});
            end
            S_PY: begin
                add_a = AW'(r_base);
                add_b = -8'({4'b0000, entry[3:0]});
            end
            S_ADV: begin
                add_b = ADVANCE;
            end
            default: begin
                add_a = AW'(r_cox);
                add_b = '0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_cox    = r_cox;
        n_base   = r_base;
        n_px     = r_px;
        n_py     = r_py;
        n_nx     = r_nx;
        n_pen    = r_pen;
        n_slot   = r_slot;
        n_hold_v = r_hold_v;
        n_hfx    = r_hfx;
        n_hfy    = r_hfy;
        n_htx    = r_htx;
        n_hty    = r_hty;
        push      = 1'b0;
        push_last = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_char.valid) begin
                    n_pen    = 1'b0;
                    n_slot   = '0;
                    n_hold_v = 1'b0;
                    if (i_char.new_string) begin
                        n_state = S_RLX;
                    end else if (i_char.char_code < FIRST_CODE) begin
                        n_state = S_ADV;
                    end else begin
                        n_state = S_PX;
                    end
                end
            end
            S_RLX: begin
                n_cox   = add_sum;
                n_state = S_RLY;
            end
            S_RLY: begin
                n_base  = add_sum;
                n_state = (r_code < FIRST_CODE) ? S_ADV : S_PX;
            end
            S_PX: begin
                if (r_slot >= SLOT_LIMIT) begin
                    n_state = S_FLUSH;
                end else if (entry[UP_BIT]) begin
                    n_pen  = 1'b0;
                    n_slot = r_slot + 4'd1;
                end else if (!entry[PT_BIT]) begin
                    n_state = S_FLUSH;
                end else begin
                    n_nx    = add_sum;
                    n_state = S_PY;
                end
            end
            S_PY: begin
                // Hold here while the previous segment cannot leave
                if (!(r_pen && r_hold_v && !can_push)) begin
                    if (r_pen) begin
                        push     = r_hold_v;
                        n_hold_v = 1'b1;
                        n_hfx    = r_px;
                        n_hfy    = r_py;
                        n_htx    = r_nx;
                        n_hty    = add_sum;
                    end
                    n_px    = r_nx;
                    n_py    = add_sum;
                    n_pen   = 1'b1;
                    n_slot  = r_slot + 4'd1;
                    n_state = S_PX;
                end
            end
            S_FLUSH: begin
                if (!r_hold_v) begin
                    n_state = S_ADV;
                end else if (can_push) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    n_hold_v  = 1'b0;
                    n_state   = S_ADV;
                end
            end
            S_ADV: begin
                n_cox   = add_sum;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign push_seg.from_x       = COORD_OUT_BITS'(r_hfx);
    assign push_seg.from_y       = COORD_OUT_BITS'(r_hfy);
    assign push_seg.to_x         = COORD_OUT_BITS'(r_htx);
    assign push_seg.to_y         = COORD_OUT_BITS'(r_hty);
    assign push_seg.last_segment = push_last;

    vfsg_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_seg      (push_seg),
        .o_can_push (can_push),
        .o_valid    (o_seg.valid),
        .i_ready    (o_seg.ready),
        .o_seg      (out_seg)
    );

    assign o_seg.from_x       = out_seg.from_x;
    assign o_seg.from_y       = out_seg.from_y;
    assign o_seg.to_x         = out_seg.to_x;
    assign o_seg.to_y         = out_seg.to_y;
    assign o_seg.last_segment = out_seg.last_segment;

    assign i_char.ready = (r_state == S_IDLE);

    // Control state and pen origin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cox    <= '0;
            r_base   <= '0;
            r_pen    <= 1'b0;
            r_slot   <= '0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cox    <= n_cox;
            r_base   <= n_base;
            r_pen    <= n_pen;
            r_slot   <= n_slot;
            r_hold_v <= n_hold_v;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_char.valid) begin
            r_code <= i_char.char_code;
            r_ox   <= i_char.origin_x;
            r_oy   <= i_char.origin_y;
        end
        r_px  <= n_px;
        r_py  <= n_py;
        r_nx  <= n_nx;
        r_hfx <= n_hfx;
        r_hfy <= n_hfy;
        r_htx <= n_htx;
        r_hty <= n_hty;
    end
endmodule

/* rtl/core/vfsg_checker.sv */
// Port-level assertions for the vector font stroke generator, bound to the top level.
// Depends on vfsg_pkg for the field widths.
module vfsg_checker import vfsg_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [COORD_OUT_BITS-1:0] i_from_x,
    input logic [COORD_OUT_BITS-1:0] i_to_y,
    input logic                      i_last
);
    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("segment valid straight after reset");

    // A stalled segment holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_from_x) && $stable(i_to_y)
            && $stable(i_last))
        else $error("stalled segment changed");

    // A character keeps the block busy at least into the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("new character taken while one is in progress");

    // A segment that is not the last leaves its character unfinished
    a_not_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last |=> !i_in_ready)
        else $error("character ended without a last segment");
endmodule

bind vector_font_stroke_generator vfsg_checker u_vfsg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_char.valid),
    .i_in_ready  (i_char.ready),
    .i_out_valid (o_seg.valid),
    .i_out_ready (o_seg.ready),
    .i_from_x    (o_seg.from_x),
    .i_to_y      (o_seg.to_y),
    .i_last      (o_seg.last_segment)
);
